// ----- hdl/trs_model_matrix_compose_top_defines.svh -----
// Assertion macros shared by the checker of the model matrix block.
`ifndef TRS_MODEL_MATRIX_COMPOSE_TOP_DEFINES_SVH
`define TRS_MODEL_MATRIX_COMPOSE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/trs_pkg.sv -----
// ----------------------------------------------------------------------------
// trs_pkg
// Types, widths and constants of the TRS model matrix pipeline.
// ----------------------------------------------------------------------------
package trs_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // Width of a sine, cosine or rotation product: magnitude up to 2^FRAC_BITS
    localparam int TRIG_W = FRAC_BITS + 2;

    localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;
    localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;

    // Horner divisors; the sine series uses six, its last slot is the x*t multiply
    localparam int STEPS = 7;
    localparam int SIN_DIV [0:STEPS-1] = '{156, 110, 72, 42, 20, 6, 1};
    localparam int COS_DIV [0:STEPS-1] = '{182, 132, 90, 56, 30, 12, 2};

    // Sine/cosine pipeline: two front stages, two per step, one rounding stage
    localparam int SC_LAT    = 2 + 2 * STEPS + 1;
    localparam int CMP_LAT   = 3;
    localparam int TOTAL_LAT = SC_LAT + CMP_LAT;

    typedef struct packed {
        logic signed [31:0] translate_x;
        logic signed [31:0] translate_y;
        logic signed [31:0] translate_z;
        logic        [15:0] angle_x;
        logic        [15:0] angle_y;
        logic        [15:0] angle_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] m_r0_c0;
        logic signed [31:0] m_r0_c1;
        logic signed [31:0] m_r0_c2;
        logic signed [31:0] m_r0_c3;
        logic signed [31:0] m_r1_c0;
        logic signed [31:0] m_r1_c1;
        logic signed [31:0] m_r1_c2;
        logic signed [31:0] m_r1_c3;
        logic signed [31:0] m_r2_c0;
        logic signed [31:0] m_r2_c1;
        logic signed [31:0] m_r2_c2;
        logic signed [31:0] m_r2_c3;
    } out_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
    } trig_t;

    // Translation and scale riding alongside the angle pipeline
    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
    } lin_t;

endpackage

// ----- hdl/trs_sincos.sv -----
// ----------------------------------------------------------------------------
// trs_sincos
// Pipelined sine and cosine of a binary angle by Horner-form series in Q30.
// ----------------------------------------------------------------------------
module trs_sincos (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [15:0]           angle,
    output logic                  out_valid,
    output trs_pkg::trig_t        trig
);

    localparam int AB   = trs_pkg::ANGLE_BITS;
    localparam int F    = trs_pkg::FRAC_BITS;
    localparam int W    = trs_pkg::TRIG_W;
    localparam int N    = trs_pkg::STEPS;
    localparam int SH   = 30 - F;
    localparam int FPAD = 32 - AB;
    localparam logic [31:0] HALF = 32'd1 << (SH - 1);

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

    // front stage
    logic              v0_reg;
    logic [30:0]       x0_reg;
    quad_t             q0_reg;

    // after step boundaries (index 0 is after the x^2 stage)
    logic              b_v_reg  [0:N];
    logic [30:0]       b_x_reg  [0:N];
    logic [31:0]       b_x2_reg [0:N];
    quad_t             b_q_reg  [0:N];
    logic signed [31:0] b_st_reg [0:N];
    logic signed [31:0] b_ct_reg [0:N];

    // after the multiply half of each step
    logic              a_v_reg    [0:N-1];
    logic [30:0]       a_x_reg    [0:N-1];
    logic [31:0]       a_x2_reg   [0:N-1];
    quad_t             a_q_reg    [0:N-1];
    logic signed [31:0] a_ct_reg  [0:N-1];
    logic              a_sneg_reg [0:N-1];
    logic [31:0]       a_smag_reg [0:N-1];
    logic              a_cneg_reg [0:N-1];
    logic [31:0]       a_cmag_reg [0:N-1];

    logic              vo_reg;
    trs_pkg::trig_t    trig_reg;

    logic [AB-1:0]     ang;
    logic [29:0]       f;
    logic [60:0]       xp;
    logic [61:0]       x2p;

    always_comb
    begin
        ang = AB'(angle);
        f   = 30'(ang[AB-3:0]) << FPAD;
        xp  = 61'(f) * 61'(trs_pkg::HALF_PI_Q30);
        x2p = 62'(x0_reg) * 62'(x0_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg     <= 1'b0;
            b_v_reg[0] <= 1'b0;
        end
        else
        begin
            v0_reg     <= in_valid;
            b_v_reg[0] <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg      <= xp[60:30];
        q0_reg      <= quad_t'(ang[AB-1:AB-2]);
        b_x_reg[0]  <= x0_reg;
        b_x2_reg[0] <= x2p[61:30];
        b_q_reg[0]  <= q0_reg;
        b_st_reg[0] <= trs_pkg::Q30_ONE;
        b_ct_reg[0] <= trs_pkg::Q30_ONE;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        localparam int SD = trs_pkg::SIN_DIV[i];
        localparam int CD = trs_pkg::COS_DIV[i];
        localparam int SK = 32 + $clog2(SD);
        localparam int CK = 32 + $clog2(CD);
        localparam logic [63:0] SM = ((64'd1 << SK) + 64'(SD) - 64'd1) / 64'(SD);
        localparam logic [63:0] CM = ((64'd1 << CK) + 64'(CD) - 64'd1) / 64'(CD);
        localparam bit SIN_LAST = (i == N - 1);

        logic [31:0]        sop;
        logic signed [64:0] sp, cp, sn, cn;
        logic [71:0]        sqp, cqp;
        logic [31:0]        sq, cq;
        logic signed [31:0] st_new, ct_new;

        // multiply half: x^2 * t, or x * t in the final sine slot
        always_comb
        begin
            sop = SIN_LAST ? 32'(b_x_reg[i]) : b_x2_reg[i];
            sp  = ($signed({1'b0, sop}) * b_st_reg[i]) >>> 30;
            cp  = ($signed({1'b0, b_x2_reg[i]}) * b_ct_reg[i]) >>> 30;
            sn  = -sp;
            cn  = -cp;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_v_reg[i]   <= 1'b0;
                b_v_reg[i+1] <= 1'b0;
            end
            else
            begin
                a_v_reg[i]   <= b_v_reg[i];
                b_v_reg[i+1] <= a_v_reg[i];
            end
        end

        // divide half: truncating division by reciprocal multiply
        always_comb
        begin
            sqp = 72'(a_smag_reg[i]) * 72'(SM);
            cqp = 72'(a_cmag_reg[i]) * 72'(CM);
            sq  = 32'(sqp >> SK);
            cq  = 32'(cqp >> CK);
            if (SIN_LAST)
                st_new = $signed(a_smag_reg[i]);
            else
                st_new = trs_pkg::Q30_ONE - (a_sneg_reg[i] ? -$signed(sq) : $signed(sq));
            // hold once the cosine series has gone negative
            if (a_ct_reg[i] < 0)
                ct_new = a_ct_reg[i];
            else
                ct_new = trs_pkg::Q30_ONE - (a_cneg_reg[i] ? -$signed(cq) : $signed(cq));
        end

        always_ff @(posedge clk)
        begin
            a_x_reg[i]    <= b_x_reg[i];
            a_x2_reg[i]   <= b_x2_reg[i];
            a_q_reg[i]    <= b_q_reg[i];
            a_ct_reg[i]   <= b_ct_reg[i];
            a_sneg_reg[i] <= sp[64];
            a_smag_reg[i] <= sp[64] ? sn[31:0] : sp[31:0];
            a_cneg_reg[i] <= cp[64];
            a_cmag_reg[i] <= cp[64] ? cn[31:0] : cp[31:0];

            b_x_reg[i+1]  <= a_x_reg[i];
            b_x2_reg[i+1] <= a_x2_reg[i];
            b_q_reg[i+1]  <= a_q_reg[i];
            b_st_reg[i+1] <= st_new;
            b_ct_reg[i+1] <= ct_new;
        end
    end

    logic signed [31:0] c_cl;
    logic [31:0]        s_sum, c_sum;
    logic [W-1:0]       s_mag, c_mag;
    trs_pkg::trig_t     trig_next;

    always_comb
    begin
        c_cl = b_ct_reg[N];
        if (c_cl < 0)
            c_cl = '0;
        else if (c_cl > trs_pkg::Q30_ONE)
            c_cl = trs_pkg::Q30_ONE;
        s_sum = b_st_reg[N] + HALF;
        c_sum = c_cl + HALF;
        s_mag = W'(s_sum[SH+F:SH]);
        c_mag = W'(c_sum[SH+F:SH]);
        unique case (b_q_reg[N])
            QUAD_0:
            begin
                trig_next.s = $signed(s_mag);
                trig_next.c = $signed(c_mag);
            end
            QUAD_1:
            begin
                trig_next.s = $signed(c_mag);
                trig_next.c = -$signed(s_mag);
            end
            QUAD_2:
            begin
                trig_next.s = -$signed(s_mag);
                trig_next.c = -$signed(c_mag);
            end
            QUAD_3:
            begin
                trig_next.s = -$signed(c_mag);
                trig_next.c = $signed(s_mag);
            end
            default:
            begin
                trig_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else
            vo_reg <= b_v_reg[N];
    end

    always_ff @(posedge clk)
    begin
        trig_reg <= trig_next;
    end

    assign out_valid = vo_reg;
    assign trig      = trig_reg;

endmodule

// ----- hdl/trs_compose.sv -----
// ----------------------------------------------------------------------------
// trs_compose
// Three-stage rotation product, column scaling and saturation.
// ----------------------------------------------------------------------------
module trs_compose (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  trs_pkg::trig_t tx,
    input  trs_pkg::trig_t ty,
    input  trs_pkg::trig_t tz,
    input  trs_pkg::lin_t  lin,
    output logic           done,
    output trs_pkg::out_t  result
);

    localparam int F  = trs_pkg::FRAC_BITS;
    localparam int W  = trs_pkg::TRIG_W;
    localparam int VW = W + 33 - F;
    localparam logic signed [2*W-1:0] RND   = (2 * W)'(1) << (F - 1);
    localparam logic signed [W+32:0]  RND_S = (W + 33)'(1) << (F - 1);
    localparam logic signed [VW-1:0]  SMAX  = VW'(32'sh7fff_ffff);
    localparam logic signed [VW-1:0]  SMIN  = VW'($signed(32'h8000_0000));

    function automatic logic signed [W-1:0] mulq(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        p = a * b + RND;
        return p[F+W-1:F];
    endfunction

    function automatic logic signed [31:0] scl(input logic signed [W:0] r,
                                               input logic signed [31:0] s);
        logic signed [W+32:0] p;
        logic signed [VW-1:0] v;
        p = r * s + RND_S;
        v = p[W+32:F];
        if (v > SMAX)
            return 32'sh7fff_ffff;
        else if (v < SMIN)
            return $signed(32'h8000_0000);
        else
            return v[31:0];
    endfunction

    logic v1_reg, v2_reg, v3_reg;
    logic signed [W-1:0] sxsy_reg, cxsy_reg, cycz_reg, cysz_reg, sy_reg, sxcy_reg;
    logic signed [W-1:0] cxcy_reg, cxsz_reg, cxcz_reg, sxsz_reg, sxcz_reg, sz_reg, cz_reg;
    trs_pkg::lin_t       lin1_reg, lin2_reg;
    logic signed [W:0]   rot_reg [0:8];
    logic signed [W:0]   rot_next [0:8];
    trs_pkg::out_t       result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: first-level trig products
    always_ff @(posedge clk)
    begin
        sxsy_reg <= mulq(tx.s, ty.s);
        cxsy_reg <= mulq(tx.c, ty.s);
        cycz_reg <= mulq(ty.c, tz.c);
        cysz_reg <= mulq(ty.c, tz.s);
        sxcy_reg <= mulq(tx.s, ty.c);
        cxcy_reg <= mulq(tx.c, ty.c);
        cxsz_reg <= mulq(tx.c, tz.s);
        cxcz_reg <= mulq(tx.c, tz.c);
        sxsz_reg <= mulq(tx.s, tz.s);
        sxcz_reg <= mulq(tx.s, tz.c);
        sy_reg   <= ty.s;
        sz_reg   <= tz.s;
        cz_reg   <= tz.c;
        lin1_reg <= lin;
    end

    // stage 2: rotation entries
    always_comb
    begin
        rot_next[0] = (W + 1)'(cycz_reg);
        rot_next[1] = -(W + 1)'(cysz_reg);
        rot_next[2] = (W + 1)'(sy_reg);
        rot_next[3] = (W + 1)'(mulq(sxsy_reg, cz_reg)) + (W + 1)'(cxsz_reg);
        rot_next[4] = (W + 1)'(cxcz_reg) - (W + 1)'(mulq(sxsy_reg, sz_reg));
        rot_next[5] = -(W + 1)'(sxcy_reg);
        rot_next[6] = (W + 1)'(sxsz_reg) - (W + 1)'(mulq(cxsy_reg, cz_reg));
        rot_next[7] = (W + 1)'(mulq(cxsy_reg, sz_reg)) + (W + 1)'(sxcz_reg);
        rot_next[8] = (W + 1)'(cxcy_reg);
    end

    always_ff @(posedge clk)
    begin
        rot_reg  <= rot_next;
        lin2_reg <= lin1_reg;
    end

    // stage 3: scale each column, saturate, attach translation
    always_ff @(posedge clk)
    begin
        result_reg.m_r0_c0 <= scl(rot_reg[0], lin2_reg.sx);
        result_reg.m_r0_c1 <= scl(rot_reg[1], lin2_reg.sy);
        result_reg.m_r0_c2 <= scl(rot_reg[2], lin2_reg.sz);
        result_reg.m_r0_c3 <= lin2_reg.tx;
        result_reg.m_r1_c0 <= scl(rot_reg[3], lin2_reg.sx);
        result_reg.m_r1_c1 <= scl(rot_reg[4], lin2_reg.sy);
        result_reg.m_r1_c2 <= scl(rot_reg[5], lin2_reg.sz);
        result_reg.m_r1_c3 <= lin2_reg.ty;
        result_reg.m_r2_c0 <= scl(rot_reg[6], lin2_reg.sx);
        result_reg.m_r2_c1 <= scl(rot_reg[7], lin2_reg.sy);
        result_reg.m_r2_c2 <= scl(rot_reg[8], lin2_reg.sz);
        result_reg.m_r2_c3 <= lin2_reg.tz;
    end

    assign done   = v3_reg;
    assign result = result_reg;

endmodule

// ----- hdl/trs_model_matrix_compose_top.sv -----
// ----------------------------------------------------------------------------
// trs_model_matrix_compose_top
// Upper 3x4 of the model matrix T*Rx*Ry*Rz*S from translation, angles, scale.
// ----------------------------------------------------------------------------
// A transaction is taken on every cycle with start high; busy stays low, so a
// new item may follow each cycle. The result appears on result with done high
// for one cycle, after the sine/cosine pipeline (two stages to form x and
// x^2, two per series step over seven steps, one to round and fold the
// quadrant) and the matrix datapath stages (trig products, rotation entries,
// scaling with saturation). Results cannot be held off, so done must be
// taken when it is shown.
module trs_model_matrix_compose_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  trs_pkg::in_t  item,
    output logic          done,
    output trs_pkg::out_t result
);

    localparam int LAT = trs_pkg::SC_LAT;

    logic           go;
    logic           vx, vy, vz;
    trs_pkg::trig_t tx, ty, tz;
    trs_pkg::lin_t  dl_reg [0:LAT-1];

    assign busy = 1'b0;
    assign go   = start & ~busy;

    trs_sincos u_sc_x (.clk, .rst_n, .in_valid(go), .angle(item.angle_x),
                       .out_valid(vx), .trig(tx));
    trs_sincos u_sc_y (.clk, .rst_n, .in_valid(go), .angle(item.angle_y),
                       .out_valid(vy), .trig(ty));
    trs_sincos u_sc_z (.clk, .rst_n, .in_valid(go), .angle(item.angle_z),
                       .out_valid(vz), .trig(tz));

    // hold translation and scale in step with the angle pipeline
    always_ff @(posedge clk)
    begin
        dl_reg[0].tx <= item.translate_x;
        dl_reg[0].ty <= item.translate_y;
        dl_reg[0].tz <= item.translate_z;
        dl_reg[0].sx <= item.scale_x;
        dl_reg[0].sy <= item.scale_y;
        dl_reg[0].sz <= item.scale_z;
        for (int i = 1; i < LAT; i++)
            dl_reg[i] <= dl_reg[i-1];
    end

    trs_compose u_cmp (
        .clk,
        .rst_n,
        .in_valid (vx & vy & vz),
        .tx,
        .ty,
        .tz,
        .lin      (dl_reg[LAT-1]),
        .done,
        .result
    );

endmodule

// ----- hdl/trs_checker.sv -----
// ----------------------------------------------------------------------------
// trs_checker
// Port-level checks of latency and pass-through of the model matrix block.
// ----------------------------------------------------------------------------
`include "trs_model_matrix_compose_top_defines.svh"

module trs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input trs_pkg::in_t  item,
    input logic          done,
    input trs_pkg::out_t result
);

    `TRS_ASSERT_IMP(a_no_busy, 1'b1, !busy, "busy raised")
    `TRS_ASSERT_IMP(a_done_src, done, $past(start, trs_pkg::TOTAL_LAT), "done without start")
    `TRS_ASSERT_NXT(a_done_due, $past(start && !busy, trs_pkg::TOTAL_LAT - 1), done, "result missing")
    `TRS_ASSERT_IMP(a_tx_pass, done,
        result.m_r0_c3 == $past(item.translate_x, trs_pkg::TOTAL_LAT), "translation x lost")
    `TRS_ASSERT_IMP(a_tz_pass, done,
        result.m_r2_c3 == $past(item.translate_z, trs_pkg::TOTAL_LAT), "translation z lost")

endmodule

bind trs_model_matrix_compose_top trs_checker u_chk (.*);
